### sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: shared definitions
// Constants, command and status types shared by the controller and datapath.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int FREQ_W   = 32;
   localparam int WORD_W   = 32;
   localparam int DIV_W    = 27;
   localparam int CNT_W    = $clog2(DIV_W + 1);
   localparam int N_W      = 6;
   localparam int PRE_W    = 13;
   localparam int V_W      = 2;
   localparam int Q_W      = 20;
   localparam int PROD_W   = 20;

   localparam int SRC_CLOCK_INT = 80000000;
   localparam int PRE_MAX_INT   = 8191;
   localparam int N_MAX_INT     = 63;

   localparam logic [DIV_W-1:0]  SRC_CLOCK   = DIV_W'(SRC_CLOCK_INT);
   localparam logic [FREQ_W-1:0] SRC_FREQ    = FREQ_W'(SRC_CLOCK_INT);
   localparam logic [FREQ_W-1:0] FLOOR_FREQ  =
      FREQ_W'(SRC_CLOCK_INT / ((PRE_MAX_INT + 1) * (N_MAX_INT + 1)));
   localparam logic [WORD_W-1:0] MIN_WORD    = 32'h7FFF_F020;
   localparam logic [WORD_W-1:0] BYPASS_WORD = 32'h8000_0000;
   localparam logic [PRE_W-1:0]  PRE_MAX     = PRE_W'(PRE_MAX_INT);
   localparam logic [N_W-1:0]    N_MAX       = N_W'(N_MAX_INT);
   localparam logic [N_W-1:0]    N_FIRST     = N_W'(1);
   localparam logic [V_W-1:0]    V_LAST      = V_W'(3);

   typedef enum logic [1:0] {
      DIV_SRC_N,
      DIV_SRC_Q,
      DIV_SRC_CF
   } div_src_type;

   typedef enum logic [1:0] {
      RES_BYPASS,
      RES_MIN,
      RES_BEST,
      RES_CAND
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        init_search;
      logic        div_start;
      div_src_type div_src;
      logic        latch_q;
      logic        set_cand;
      logic        eval;
      logic        next_v;
      logic        next_n;
      logic        set_result;
      res_sel_type res_sel;
      logic        load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic f_over;
      logic f_under;
      logic div_busy;
      logic cf_exact;
      logic last_v;
      logic last_n;
      logic out_free;
   } ctrl_status_type;

endpackage

### sv/scd_divider.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: iterative divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scd_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [scd_pkg::DIV_W-1:0] dividend,
   input  logic [scd_pkg::DIV_W-1:0] divisor,
   output logic                      busy,
   output logic [scd_pkg::DIV_W-1:0] quotient
);
   import scd_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### sv/scd_datapath.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: datapath
// Request register, candidate arithmetic, best-so-far tracking, result register.
// ----------------------------------------------------------------------------
module scd_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  scd_pkg::ctrl_cmd_type      cmd,
   output scd_pkg::ctrl_status_type   status,
   input  logic [scd_pkg::FREQ_W-1:0] req_freq,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [scd_pkg::WORD_W-1:0] rsp_word,
   output logic                       rsp_bypass
);
   import scd_pkg::*;

   logic [FREQ_W-1:0] f_ff;
   logic [N_W-1:0]    n_ff;
   logic [V_W-1:0]    v_ff;
   logic [Q_W-1:0]    q_ff;
   logic [PRE_W-1:0]  pre_ff, pre_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]  top_cf_ff;
   logic [WORD_W-1:0] best_word_ff;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_bypass_ff;
   logic              rsp_valid_ff;

   logic [DIV_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_divisor;
   logic              div_busy;
   logic [DIV_W-1:0]  div_quotient;
   logic [Q_W:0]      sum;
   logic [Q_W:0]      sum_less;
   logic [N_W:0]      n_plus;
   logic [PRE_W:0]    pre_plus;
   logic [PRE_W+N_W+1:0] prod_full;
   logic [WORD_W-1:0] cand_word;
   logic [DIV_W-1:0]  f_low;
   logic              cf_exact;
   logic              cf_better;

   scd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      f_low  = f_ff[DIV_W-1:0];
      n_plus = {1'b0, n_ff} + (N_W+1)'(1);
      case (cmd.div_src)
         DIV_SRC_N: begin
            div_dividend = SRC_CLOCK;
            div_divisor  = DIV_W'(n_plus);
         end
         DIV_SRC_Q: begin
            div_dividend = div_quotient;
            div_divisor  = f_low;
         end
         DIV_SRC_CF: begin
            div_dividend = SRC_CLOCK;
            div_divisor  = DIV_W'(prod_ff);
         end
         default: begin
            div_dividend = SRC_CLOCK;
            div_divisor  = f_low;
         end
      endcase
   end

   always_comb begin
      sum      = {1'b0, q_ff} + (Q_W+1)'(v_ff);
      sum_less = sum - (Q_W+1)'(2);
      if (sum <= (Q_W+1)'(2)) begin
         pre_in = '0;
      end else if (sum_less > (Q_W+1)'(PRE_MAX)) begin
         pre_in = PRE_MAX;
      end else begin
         pre_in = sum_less[PRE_W-1:0];
      end
      pre_plus  = {1'b0, pre_in} + (PRE_W+1)'(1);
      prod_full = pre_plus * n_plus;
      prod_in   = prod_full[PROD_W-1:0];
   end

   always_comb begin
      cand_word = {1'b0, pre_ff, n_ff, {N_W{1'b0}}, n_plus[N_W:1]};
      cf_exact  = (div_quotient == f_low);
      cf_better = (div_quotient < f_low) && (div_quotient > top_cf_ff);
      case (cmd.res_sel)
         RES_BYPASS: result_in = BYPASS_WORD;
         RES_MIN:    result_in = MIN_WORD;
         RES_BEST:   result_in = best_word_ff;
         RES_CAND:   result_in = cand_word;
         default:    result_in = best_word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         f_ff <= req_freq;
      end
      if (cmd.init_search) begin
         n_ff         <= N_FIRST;
         top_cf_ff    <= '0;
         best_word_ff <= '0;
      end else begin
         if (cmd.next_n) begin
            n_ff <= n_ff + N_W'(1);
         end
         if (cmd.eval && cf_better) begin
            top_cf_ff    <= div_quotient;
            best_word_ff <= cand_word;
         end
      end
      if (cmd.latch_q) begin
         q_ff <= div_quotient[Q_W-1:0];
         v_ff <= '0;
      end else if (cmd.next_v) begin
         v_ff <= v_ff + V_W'(1);
      end
      if (cmd.set_cand) begin
         pre_ff  <= pre_in;
         prod_ff <= prod_in;
      end
      if (cmd.set_result) begin
         result_ff <= result_in;
      end
      if (cmd.load_out) begin
         rsp_word_ff   <= result_ff;
         rsp_bypass_ff <= (result_ff == BYPASS_WORD);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.f_over   = (f_ff >= SRC_FREQ);
      status.f_under  = (f_ff < FLOOR_FREQ);
      status.div_busy = div_busy;
      status.cf_exact = cf_exact;
      status.last_v   = (v_ff == V_LAST);
      status.last_n   = (n_ff == N_MAX);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_bypass = rsp_bypass_ff;

endmodule

### sv/scd_ctrl.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: controller
// Sequences the divider search and the result hand-off.
// ----------------------------------------------------------------------------
module scd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  scd_pkg::ctrl_status_type status,
   output scd_pkg::ctrl_cmd_type    cmd
);
   import scd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_START_N,
      ST_WAIT_N,
      ST_START_Q,
      ST_WAIT_Q,
      ST_CAND,
      ST_START_CF,
      ST_WAIT_CF,
      ST_EVAL,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_src = DIV_SRC_N;
      cmd.res_sel = RES_BEST;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.f_over) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_BYPASS;
               state_in       = ST_FINISH;
            end else if (status.f_under) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_MIN;
               state_in       = ST_FINISH;
            end else begin
               cmd.init_search = 1'b1;
               state_in        = ST_START_N;
            end
         end
         ST_START_N: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_N;
            state_in      = ST_WAIT_N;
         end
         ST_WAIT_N: begin
            if (!status.div_busy) begin
               state_in = ST_START_Q;
            end
         end
         ST_START_Q: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_Q;
            state_in      = ST_WAIT_Q;
         end
         ST_WAIT_Q: begin
            if (!status.div_busy) begin
               cmd.latch_q = 1'b1;
               state_in    = ST_CAND;
            end
         end
         ST_CAND: begin
            cmd.set_cand = 1'b1;
            state_in     = ST_START_CF;
         end
         ST_START_CF: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_CF;
            state_in      = ST_WAIT_CF;
         end
         ST_WAIT_CF: begin
            if (!status.div_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.cf_exact) begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_CAND;
               state_in       = ST_FINISH;
            end else begin
               cmd.eval = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!status.last_v) begin
               cmd.next_v = 1'b1;
               state_in   = ST_CAND;
            end else if (!status.last_n) begin
               cmd.next_n = 1'b1;
               state_in   = ST_START_N;
            end else begin
               cmd.set_result = 1'b1;
               cmd.res_sel    = RES_BEST;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/spi_clock_divider_search.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: top level
// Turns a requested SPI clock frequency into a packed 80 MHz clock word.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Requests at or above 80 MHz, and below
// the slowest setting of 152 Hz, skip the search. Any other request runs a
// search over dividers N = 1..63 on one shared 27-step radix-2 divider: each N
// costs two divisions for the prescaler estimate and one per each of four
// candidates. An exact match ends the search early, and a finished search may
// wait for the previous transaction to leave the result register. The result
// register holds a finished transaction while the next request is accepted.
module spi_clock_divider_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] req_freq
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] clock_word
   output logic        rsp_tuser    // [0] sysclk_bypass
);
   import scd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   scd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_freq   (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_word   (rsp_tdata),
      .rsp_bypass (rsp_tuser)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a search is running");

   a_bypass_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == BYPASS_WORD)
      else $error("bypass flag without the bypass word");

   a_bypass_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31] |-> rsp_tuser)
      else $error("bypass bit set without the bypass flag");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_tvalid || rsp_tready)
      else $error("result register overwritten before it was taken");

endmodule

### verif/tb_spi_clock_divider_search.sv
// ----------------------------------------------------------------------------
// SPI clock divider search: testbench
// Sends requested frequencies over the request stream and checks every clock
// word and bypass flag against an in-bench search predictor. A short table of
// corner frequencies runs first, then random requests that favour values at or
// next to exactly reachable ones. Back-pressure and sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_spi_clock_divider_search;

   import scd_pkg::*;

   typedef struct {
      logic [31:0] clock_word;
      logic        bypass;
   } clock_result_type;

   typedef struct {
      logic [31:0] freq;
      bit          typed;
      logic [31:0] word;
   } corner_row_type;

   localparam int N_CORNER = 17;
   localparam int N_RANDOM = 84;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] req_freq
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] clock_word
   logic        rsp_tuser;   // [0] sysclk_bypass

   clock_result_type pending_words[$];
   int               failures = 0;
   int               send_gap_pct = 10;
   int               recv_stall_pct = 56;

   corner_row_type corner_rows [N_CORNER] = '{
      '{32'd0,           1'b1, MIN_WORD},
      '{32'd1,           1'b1, MIN_WORD},
      '{32'd151,         1'b1, MIN_WORD},
      '{32'd152,         1'b0, 32'd0},
      '{32'd153,         1'b0, 32'd0},
      '{32'd1000,        1'b0, 32'd0},
      '{32'd500000,      1'b0, 32'd0},
      '{32'd1000000,     1'b0, 32'd0},
      '{32'd10000000,    1'b0, 32'd0},
      '{32'd20000000,    1'b0, 32'd0},
      '{32'd26666666,    1'b0, 32'd0},
      '{32'd40000000,    1'b0, 32'd0},
      '{32'd79999999,    1'b0, 32'd0},
      '{32'd80000000,    1'b1, BYPASS_WORD},
      '{32'h7FFF_FFFF,   1'b1, BYPASS_WORD},
      '{32'h8000_0000,   1'b1, BYPASS_WORD},
      '{32'hFFFF_FFFF,   1'b1, BYPASS_WORD}
   };

   spi_clock_divider_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic logic [31:0] search_clock_word(logic [31:0] freq);
      logic [31:0] best_word;
      logic [31:0] top_cf;
      logic [31:0] word;
      logic [31:0] cand_freq;
      logic [31:0] pre;
      int          base;
      int          p;
      if (freq >= SRC_FREQ) begin
         return BYPASS_WORD;
      end
      if (freq < FLOOR_FREQ) begin
         return MIN_WORD;
      end
      best_word = '0;
      top_cf    = '0;
      for (int n = 1; n <= N_MAX_INT; n++) begin
         base = int'(32'(SRC_CLOCK_INT / (n + 1)) / freq) - 1;
         for (int v = -1; v <= 2; v++) begin
            p = base + v;
            if (p > PRE_MAX_INT) begin
               pre = PRE_MAX_INT;
            end else if (p <= 0) begin
               pre = '0;
            end else begin
               pre = 32'(p);
            end
            word = 32'((n + 1) / 2) | (32'(n) << 12) | (pre << 18);
            cand_freq = 32'(SRC_CLOCK_INT) / ((pre + 32'd1) * 32'(n + 1));
            if (cand_freq == freq) begin
               return word;
            end
            if (cand_freq < freq && cand_freq > top_cf) begin
               top_cf    = cand_freq;
               best_word = word;
            end
         end
      end
      return best_word;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb_spi_clock_divider_search NOT OK");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      clock_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected transaction word %h bypass %b", $time,
                     rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            exp_res = pending_words.pop_front();
            if (rsp_tdata !== exp_res.clock_word) begin
               $display("%0t: clock_word expected %h actual %h", $time,
                        exp_res.clock_word, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== exp_res.bypass) begin
               $display("%0t: sysclk_bypass expected %b actual %b", $time,
                        exp_res.bypass, rsp_tuser);
               failures++;
            end
         end
      end
   end

   task automatic send_freq(input logic [31:0] freq, input bit typed,
                            input logic [31:0] typed_word);
      clock_result_type exp_res;
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= freq;
      do @(posedge clock); while (!req_tready);
      exp_res.clock_word = typed ? typed_word : search_clock_word(freq);
      exp_res.bypass     = (exp_res.clock_word == BYPASS_WORD);
      pending_words.push_back(exp_res);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] freq;
      int          pick;
      int          pre;
      int          n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_CORNER; i++) begin
         send_freq(corner_rows[i].freq, corner_rows[i].typed, corner_rows[i].word);
      end
      wait_drained();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            wait_drained();
            send_gap_pct   = 56;
            recv_stall_pct = 10;
         end else if (i == 2 * N_RANDOM / 3) begin
            wait_drained();
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            freq = $urandom_range(32'hFFFF_FFFF, SRC_CLOCK_INT);
         end else if (pick < 14) begin
            freq = $urandom_range(151, 0);
         end else if (pick < 55) begin
            pre  = $urandom_range(2, 0) != 0 ? $urandom_range(63, 0)
                                             : $urandom_range(PRE_MAX_INT, 0);
            n    = $urandom_range(N_MAX_INT, 1);
            freq = 32'(SRC_CLOCK_INT / ((pre + 1) * (n + 1)));
            freq = freq + $urandom_range(2, 0) - 1;
         end else begin
            freq = $urandom >> $urandom_range(31, 5);
         end
         send_freq(freq, 1'b0, '0);
      end
      wait_drained();
      repeat (20) @(negedge clock);

      if (failures == 0) begin
         $display("tb_spi_clock_divider_search OK");
      end else begin
         $display("tb_spi_clock_divider_search NOT OK");
      end
      $finish;
   end

endmodule

### files.f
sv/scd_pkg.sv
sv/scd_divider.sv
sv/scd_datapath.sv
sv/scd_ctrl.sv
sv/spi_clock_divider_search.sv
verif/tb_spi_clock_divider_search.sv
